### hdl/slos_pkg.sv
// slos_pkg: shared types, constants and helpers for the skip-list ordered set
// depends on: nothing
`default_nettype none
package slos_pkg;

	localparam int POOL_SIZE  = 1024;
	localparam int TOP_LEVEL  = 9;
	localparam int LEVELS     = TOP_LEVEL + 1;
	localparam int NODE_W     = $clog2(POOL_SIZE);
	localparam int LINK_W     = NODE_W + 1;
	localparam int LVL_W      = 4;
	localparam int LINK_DEPTH = POOL_SIZE * LEVELS;
	localparam int LINK_AW    = $clog2(LINK_DEPTH);
	localparam int KEY_W      = 32;

	typedef logic [NODE_W-1:0]  node_t;
	typedef logic [LINK_W-1:0]  link_t;
	typedef logic [LVL_W-1:0]   lvl_t;
	typedef logic [LINK_AW-1:0] link_addr_t;
	typedef logic [LINK_W-1:0]  count_t;

	localparam link_t        TAIL_LINK = link_t'(POOL_SIZE);
	localparam count_t       POOL_CNT  = count_t'(POOL_SIZE);
	localparam lvl_t         TOP_LVL   = lvl_t'(TOP_LEVEL);
	localparam logic [31:0]  LFSR_TAPS = 32'h8020_0003;
	localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

	typedef enum logic [1:0] {
		CMD_ADD      = 2'd0,
		CMD_REMOVE   = 2'd1,
		CMD_CONTAINS = 2'd2,
		CMD_CLEAR    = 2'd3
	} cmd_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_LVL,
		S_LVL_WAIT,
		S_HOP,
		S_CMP,
		S_DECIDE,
		S_POP_WAIT,
		S_DRAW,
		S_INS_KEY,
		S_INS_LINK,
		S_INS_PRED,
		S_RM_TOP,
		S_RM_READ,
		S_RM_WRITE,
		S_DONE
	} state_t;

	// links at or above the pool size all mean the tail
	function automatic link_t clamp_link(input link_t v);
		clamp_link = v[NODE_W] ? TAIL_LINK : v;
	endfunction

	function automatic link_addr_t link_addr(input node_t n, input lvl_t l);
		link_addr = link_addr_t'(n) * link_addr_t'(LEVELS) + link_addr_t'(l);
	endfunction

endpackage
`default_nettype wire

### hdl/slos_req_if.sv
// slos_req_if: request channel (cmd, key) with valid/ready
// depends on: slos_pkg
`default_nettype none
interface slos_req_if;
	logic                              valid;
	logic                              ready;
	slos_pkg::cmd_t                    cmd;
	logic signed [slos_pkg::KEY_W-1:0] key;

	modport source (output valid, output cmd, output key, input ready);
	modport sink (input valid, input cmd, input key, output ready);
endinterface
`default_nettype wire

### hdl/slos_rsp_if.sv
// slos_rsp_if: response channel (success, pool_full) with valid/ready
// depends on: nothing
`default_nettype none
interface slos_rsp_if;
	logic valid;
	logic ready;
	logic success;
	logic pool_full;

	modport source (output valid, output success, output pool_full, input ready);
	modport sink (input valid, input success, input pool_full, output ready);
endinterface
`default_nettype wire

### hdl/slos_ram.sv
// slos_ram: generic single-write, single-read RAM with registered read data
// depends on: nothing
`default_nettype none
module slos_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### hdl/skip_list_ordered_set.sv
// skip_list_ordered_set: top level, sequencer and node memories of the skip list
// depends on: slos_pkg, slos_req_if, slos_rsp_if, slos_ram
//
// Usage: requests (cmd, key) arrive on req; one response (success, pool_full)
// per request leaves on rsp. Commands: add, remove, contains, clear.
// The block works on one request at a time; req.ready is high only while idle.
// A search walks down ten levels from the head. A level still at the head takes
// its first link from a register, any other level reads it from the link memory;
// each hop reads a key and a link in parallel, then compares, and a level ends on
// the tail or on a failed compare. Add then pops a free node, draws the node's
// level one coin flip at a time, writes the key, and links the node and updates
// its predecessor at each level; remove reads the node's top level, then reads
// and rewrites each level. Every request is taken while idle and ends by loading
// the output register; clear does only that. The single read port of the link
// memory shapes these steps.
// The result sits in an output register; a new request is taken while it waits
// to be taken, but the next result is held until rsp.ready frees the register.
// Reset empties the set at once (head links to tail, full free pool, LFSR 1);
// no clearing pass runs. cfg_we/cfg_wdata reload the level LFSR (zero loads 1)
// and must be written only while the block is idle; the block does not enforce it.
`default_nettype none
module skip_list_ordered_set (
	input  wire logic        clk,
	input  wire logic        arst_n,
	slos_req_if.sink         req,
	slos_rsp_if.source       rsp,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata
);
	slos_pkg::state_t state_q, state_d;

	slos_pkg::cmd_t                    cmd_q;
	logic signed [slos_pkg::KEY_W-1:0] key_q;
	slos_pkg::node_t                   p_q;
	logic                              ph_q;
	slos_pkg::link_t                   c_q;
	slos_pkg::lvl_t                    lvl_q;
	slos_pkg::lvl_t                    level_q;
	slos_pkg::count_t                  hops_q;
	logic                              found_q;
	slos_pkg::node_t                   n_q;
	slos_pkg::node_t                   pred_q [slos_pkg::LEVELS];
	logic                              predh_q [slos_pkg::LEVELS];
	slos_pkg::link_t                   succ_q [slos_pkg::LEVELS];
	slos_pkg::link_t                   head_q [slos_pkg::LEVELS];
	slos_pkg::count_t                  free_cnt_q;
	slos_pkg::count_t                  low_q;
	logic [31:0]                       lfsr_q;
	logic                              res_ok_q, res_full_q;
	logic                              ovalid_q, osucc_q, ofull_q;

	// memory ports
	logic                         link_we;
	slos_pkg::link_addr_t         link_waddr, link_raddr;
	slos_pkg::link_t              link_wdata, link_rdata;
	logic                         key_we;
	slos_pkg::node_t              key_raddr;
	logic [slos_pkg::KEY_W-1:0]   key_rdata;
	logic                         top_we;
	slos_pkg::lvl_t               top_rdata;
	logic                         stk_we;
	slos_pkg::node_t              stk_waddr, stk_raddr;
	slos_pkg::node_t              stk_rdata;

	logic hop_go, cmp_adv, load_out;
	slos_pkg::link_t rm_link;

	slos_ram #(.WIDTH(slos_pkg::LINK_W), .DEPTH(slos_pkg::LINK_DEPTH)) u_links (
		.clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
		.raddr(link_raddr), .rdata(link_rdata)
	);
	slos_ram #(.WIDTH(slos_pkg::KEY_W), .DEPTH(slos_pkg::POOL_SIZE)) u_keys (
		.clk(clk), .we(key_we), .waddr(n_q), .wdata(key_q),
		.raddr(key_raddr), .rdata(key_rdata)
	);
	// top level of the found node is read while the request is decided
	slos_ram #(.WIDTH(slos_pkg::LVL_W), .DEPTH(slos_pkg::POOL_SIZE)) u_tops (
		.clk(clk), .we(top_we), .waddr(n_q), .wdata(level_q),
		.raddr(succ_q[0][slos_pkg::NODE_W-1:0]), .rdata(top_rdata)
	);
	slos_ram #(.WIDTH(slos_pkg::NODE_W), .DEPTH(slos_pkg::POOL_SIZE)) u_stack (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(n_q),
		.raddr(stk_raddr), .rdata(stk_rdata)
	);

	assign req.ready     = (state_q == slos_pkg::S_IDLE);
	assign rsp.valid     = ovalid_q;
	assign rsp.success   = osucc_q;
	assign rsp.pool_full = ofull_q;
	assign load_out      = (state_q == slos_pkg::S_DONE) && (!ovalid_q || rsp.ready);
	assign rm_link       = slos_pkg::clamp_link(link_rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= slos_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		hop_go     = !c_q[slos_pkg::NODE_W] && (hops_q < slos_pkg::POOL_CNT);
		cmp_adv    = $signed(key_rdata) < key_q;
		link_we    = 1'b0;
		link_waddr = slos_pkg::link_addr(n_q, lvl_q);
		link_wdata = succ_q[lvl_q];
		link_raddr = slos_pkg::link_addr(p_q, lvl_q);
		key_we     = 1'b0;
		key_raddr  = c_q[slos_pkg::NODE_W-1:0];
		top_we     = 1'b0;
		stk_we     = 1'b0;
		stk_waddr  = free_cnt_q[slos_pkg::NODE_W-1:0];
		stk_raddr  = slos_pkg::node_t'(free_cnt_q - 1'b1);
		unique case (state_q)
			slos_pkg::S_IDLE: begin
				if (req.valid) begin
					state_d = (req.cmd == slos_pkg::CMD_CLEAR) ? slos_pkg::S_DONE
					                                           : slos_pkg::S_LVL;
				end
			end
			slos_pkg::S_LVL: begin
				state_d = ph_q ? slos_pkg::S_HOP : slos_pkg::S_LVL_WAIT;
			end
			slos_pkg::S_LVL_WAIT: state_d = slos_pkg::S_HOP;
			slos_pkg::S_HOP: begin
				link_raddr = slos_pkg::link_addr(c_q[slos_pkg::NODE_W-1:0], lvl_q);
				if (hop_go) begin
					state_d = slos_pkg::S_CMP;
				end else begin
					state_d = (lvl_q == '0) ? slos_pkg::S_DECIDE : slos_pkg::S_LVL;
				end
			end
			slos_pkg::S_CMP: begin
				if (cmp_adv) begin
					state_d = slos_pkg::S_HOP;
				end else begin
					state_d = (lvl_q == '0) ? slos_pkg::S_DECIDE : slos_pkg::S_LVL;
				end
			end
			slos_pkg::S_DECIDE: begin
				priority if (cmd_q == slos_pkg::CMD_ADD && !found_q
				             && free_cnt_q != '0) begin
					state_d = slos_pkg::S_POP_WAIT;
				end else if (cmd_q == slos_pkg::CMD_REMOVE && found_q
				             && !succ_q[0][slos_pkg::NODE_W]) begin
					state_d = slos_pkg::S_RM_TOP;
				end else begin
					state_d = slos_pkg::S_DONE;
				end
			end
			slos_pkg::S_POP_WAIT: state_d = slos_pkg::S_DRAW;
			slos_pkg::S_DRAW: begin
				if (!lfsr_q[0] || (level_q + 1'b1 == slos_pkg::TOP_LVL)) begin
					state_d = slos_pkg::S_INS_KEY;
				end
			end
			slos_pkg::S_INS_KEY: begin
				key_we  = 1'b1;
				top_we  = 1'b1;
				state_d = slos_pkg::S_INS_LINK;
			end
			slos_pkg::S_INS_LINK: begin
				link_we = 1'b1;
				state_d = slos_pkg::S_INS_PRED;
			end
			slos_pkg::S_INS_PRED: begin
				link_we    = !predh_q[lvl_q];
				link_waddr = slos_pkg::link_addr(pred_q[lvl_q], lvl_q);
				link_wdata = slos_pkg::link_t'(n_q);
				state_d    = (lvl_q == level_q) ? slos_pkg::S_DONE : slos_pkg::S_INS_LINK;
			end
			slos_pkg::S_RM_TOP: state_d = slos_pkg::S_RM_READ;
			slos_pkg::S_RM_READ: begin
				link_raddr = slos_pkg::link_addr(n_q, lvl_q);
				state_d    = slos_pkg::S_RM_WRITE;
			end
			slos_pkg::S_RM_WRITE: begin
				link_we    = !predh_q[lvl_q]
				             && (succ_q[lvl_q] == slos_pkg::link_t'(n_q));
				link_waddr = slos_pkg::link_addr(pred_q[lvl_q], lvl_q);
				link_wdata = rm_link;
				if (lvl_q == '0) begin
					stk_we  = free_cnt_q < slos_pkg::POOL_CNT;
					state_d = slos_pkg::S_DONE;
				end else begin
					state_d = slos_pkg::S_RM_READ;
				end
			end
			slos_pkg::S_DONE: begin
				if (load_out) begin
					state_d = slos_pkg::S_IDLE;
				end
			end
			default: state_d = slos_pkg::S_IDLE;
		endcase
	end

	// datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_cnt_q <= slos_pkg::POOL_CNT;
			low_q      <= slos_pkg::POOL_CNT;
			lfsr_q     <= 32'd1;
			ovalid_q   <= 1'b0;
			for (int i = 0; i < slos_pkg::LEVELS; i++) begin
				head_q[i] <= slos_pkg::TAIL_LINK;
			end
		end else begin
			if (cfg_we) begin
				lfsr_q <= (cfg_wdata == '0) ? 32'd1 : cfg_wdata;
			end
			if (load_out) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				slos_pkg::S_IDLE: begin
					if (req.valid && req.cmd == slos_pkg::CMD_CLEAR) begin
						free_cnt_q <= slos_pkg::POOL_CNT;
						low_q      <= slos_pkg::POOL_CNT;
						for (int i = 0; i < slos_pkg::LEVELS; i++) begin
							head_q[i] <= slos_pkg::TAIL_LINK;
						end
					end
				end
				slos_pkg::S_DECIDE: begin
					if (cmd_q == slos_pkg::CMD_ADD && !found_q && free_cnt_q != '0) begin
						free_cnt_q <= free_cnt_q - 1'b1;
					end
				end
				slos_pkg::S_POP_WAIT: begin
					// entries below the low-water mark were never overwritten
					if (free_cnt_q < low_q) begin
						low_q <= free_cnt_q;
					end
				end
				slos_pkg::S_DRAW: begin
					lfsr_q <= (lfsr_q >> 1) ^ (lfsr_q[0] ? slos_pkg::LFSR_TAPS : 32'd0);
				end
				slos_pkg::S_INS_PRED: begin
					if (predh_q[lvl_q]) begin
						head_q[lvl_q] <= slos_pkg::link_t'(n_q);
					end
				end
				slos_pkg::S_RM_WRITE: begin
					if (predh_q[lvl_q] && succ_q[lvl_q] == slos_pkg::link_t'(n_q)) begin
						head_q[lvl_q] <= rm_link;
					end
					if (lvl_q == '0 && free_cnt_q < slos_pkg::POOL_CNT) begin
						free_cnt_q <= free_cnt_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (load_out) begin
			osucc_q <= res_ok_q;
			ofull_q <= res_full_q;
		end
		unique case (state_q)
			slos_pkg::S_IDLE: begin
				cmd_q    <= req.cmd;
				key_q    <= req.key;
				p_q      <= '0;
				ph_q     <= 1'b1;
				lvl_q    <= slos_pkg::TOP_LVL;
				res_ok_q <= 1'b1;
				res_full_q <= 1'b0;
			end
			slos_pkg::S_LVL: begin
				c_q    <= slos_pkg::clamp_link(head_q[lvl_q]);
				hops_q <= '0;
			end
			slos_pkg::S_LVL_WAIT: c_q <= rm_link;
			slos_pkg::S_HOP: begin
				if (!hop_go) begin
					pred_q[lvl_q]  <= p_q;
					predh_q[lvl_q] <= ph_q;
					succ_q[lvl_q]  <= c_q;
					if (lvl_q == '0) begin
						found_q <= c_q[slos_pkg::NODE_W] && (key_q == slos_pkg::KEY_MAX);
					end else begin
						lvl_q <= lvl_q - 1'b1;
					end
				end
			end
			slos_pkg::S_CMP: begin
				if (cmp_adv) begin
					p_q    <= c_q[slos_pkg::NODE_W-1:0];
					ph_q   <= 1'b0;
					c_q    <= rm_link;
					hops_q <= hops_q + 1'b1;
				end else begin
					pred_q[lvl_q]  <= p_q;
					predh_q[lvl_q] <= ph_q;
					succ_q[lvl_q]  <= c_q;
					if (lvl_q == '0) begin
						found_q <= ($signed(key_rdata) == key_q);
					end else begin
						lvl_q <= lvl_q - 1'b1;
					end
				end
			end
			slos_pkg::S_DECIDE: begin
				n_q        <= succ_q[0][slos_pkg::NODE_W-1:0];
				res_full_q <= 1'b0;
				unique case (cmd_q)
					slos_pkg::CMD_CONTAINS: res_ok_q <= found_q;
					slos_pkg::CMD_ADD: begin
						res_ok_q   <= !found_q && free_cnt_q != '0;
						res_full_q <= !found_q && free_cnt_q == '0;
					end
					slos_pkg::CMD_REMOVE: begin
						res_ok_q <= found_q && !succ_q[0][slos_pkg::NODE_W];
					end
					default: res_ok_q <= 1'b1;
				endcase
			end
			slos_pkg::S_POP_WAIT: begin
				n_q     <= (free_cnt_q < low_q) ? free_cnt_q[slos_pkg::NODE_W-1:0]
				                                : stk_rdata;
				level_q <= '0;
			end
			slos_pkg::S_DRAW: begin
				if (lfsr_q[0]) begin
					level_q <= level_q + 1'b1;
				end
			end
			slos_pkg::S_INS_KEY: lvl_q <= '0;
			slos_pkg::S_INS_PRED: begin
				if (lvl_q != level_q) begin
					lvl_q <= lvl_q + 1'b1;
				end
			end
			slos_pkg::S_RM_TOP: begin
				lvl_q <= (top_rdata > slos_pkg::TOP_LVL) ? slos_pkg::TOP_LVL : top_rdata;
			end
			slos_pkg::S_RM_WRITE: begin
				if (lvl_q != '0) begin
					lvl_q <= lvl_q - 1'b1;
				end
			end
			default: ;
		endcase
	end

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_cnt_q <= slos_pkg::POOL_CNT)
		else $error("free count above pool size");

	// the mark catches up with a pop in the cycle after it
	a_low_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != slos_pkg::S_POP_WAIT) |-> (low_q <= free_cnt_q))
		else $error("low-water mark above free count");

	a_full_excl: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q |-> !(osucc_q && ofull_q))
		else $error("pool_full reported with success");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.cmd == slos_pkg::CMD_CLEAR)
		|=> (free_cnt_q == slos_pkg::POOL_CNT && state_q == slos_pkg::S_DONE))
		else $error("clear did not refill the pool");

endmodule
`default_nettype wire

### tb/skip_list_ordered_set_tb.sv
// skip_list_ordered_set_tb: drives requests into the skip-list ordered set and
// checks every response against a behavioral set model held in a scoreboard
// depends on: slos_pkg, slos_req_if, slos_rsp_if, skip_list_ordered_set
`timescale 1ns / 100ps
`default_nettype none
module skip_list_ordered_set_tb;

	typedef struct packed {
		logic success;
		logic pool_full;
	} verdict_t;

	class set_scoreboard;
		bit          members[int];
		int unsigned free_nodes;
		logic [31:0] lfsr;
		verdict_t    pending_q[$];
		int          errors;

		function new();
			free_nodes = slos_pkg::POOL_SIZE;
			lfsr = 32'd1;
			errors = 0;
		endfunction

		function void load_seed(logic [31:0] v);
			lfsr = (v == 32'd0) ? 32'd1 : v;
		endfunction

		// level of a fresh node; only the lfsr advance matters to later adds
		function void draw_level();
			int unsigned lvl;
			logic bit0;
			lvl = 0;
			forever begin
				bit0 = lfsr[0];
				lfsr = lfsr >> 1;
				if (bit0) lfsr = lfsr ^ slos_pkg::LFSR_TAPS;
				if (!bit0) break;
				lvl++;
				if (lvl >= slos_pkg::TOP_LEVEL) break;
			end
		endfunction

		function void note_request(slos_pkg::cmd_t cmd, logic signed [31:0] key);
			verdict_t v;
			bit found;
			v = '0;
			// the tail sentinel matches the top key
			found = (key == slos_pkg::KEY_MAX) || members.exists(key);
			case (cmd)
				slos_pkg::CMD_CLEAR: begin
					members.delete();
					free_nodes = slos_pkg::POOL_SIZE;
					v.success = 1'b1;
				end
				slos_pkg::CMD_CONTAINS: v.success = found;
				slos_pkg::CMD_ADD: begin
					if (!found) begin
						if (free_nodes == 0) begin
							v.pool_full = 1'b1;
						end else begin
							free_nodes--;
							draw_level();
							members[key] = 1'b1;
							v.success = 1'b1;
						end
					end
				end
				default: begin
					if (found && key != slos_pkg::KEY_MAX) begin
						members.delete(key);
						free_nodes++;
						v.success = 1'b1;
					end
				end
			endcase
			pending_q.push_back(v);
		endfunction

		function void check_response(logic success, logic pool_full);
			verdict_t want;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected response success=%b pool_full=%b",
					$time, success, pool_full);
				errors++;
				return;
			end
			want = pending_q.pop_front();
			if (success !== want.success) begin
				$display("%0t: success expected %b actual %b", $time, want.success, success);
				errors++;
			end
			if (pool_full !== want.pool_full) begin
				$display("%0t: pool_full expected %b actual %b", $time, want.pool_full,
					pool_full);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [31:0] cfg_wdata;
	bit quiet;
	set_scoreboard sb;
	int fill_keys[$];

	slos_req_if req_ch();
	slos_rsp_if rsp_ch();

	skip_list_ordered_set dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("TB_ERROR");
		$finish;
	end

	function automatic int unsigned burst_len();
		if (quiet || $urandom_range(0, 3) != 0) return 0;
		return $urandom_range(1, 15);
	endfunction

	// response side: random stall bursts, check on every accepted result
	initial begin
		int unsigned n;
		rsp_ch.ready = 1'b0;
		forever begin
			n = burst_len();
			@(negedge clk);
			if (n != 0) begin
				rsp_ch.ready = 1'b0;
				repeat (n - 1) @(negedge clk);
				@(negedge clk);
			end
			rsp_ch.ready = 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			sb.check_response(rsp_ch.success, rsp_ch.pool_full);
	end

	task automatic send_request(slos_pkg::cmd_t cmd, logic signed [31:0] key);
		int unsigned gap;
		gap = burst_len();
		if (gap != 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.cmd   = cmd;
		req_ch.key   = key;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(cmd, key);
		@(negedge clk);
	endtask

	// wait until every response is in and the block has gone quiet
	task automatic drain();
		req_ch.valid = 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_seed(logic [31:0] v);
		cfg_we    = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.load_seed(v);
	endtask

	function automatic logic signed [31:0] pick_key();
		case ($urandom_range(0, 9))
			0: return 32'sh8000_0000 + $urandom_range(0, 3);
			1: return 32'sh7FFF_FFFE - $urandom_range(0, 3);
			2, 3: return $urandom;
			default: return $signed($urandom_range(0, 24)) - 12;
		endcase
	endfunction

	function automatic slos_pkg::cmd_t pick_cmd();
		if ($urandom_range(0, 60) == 0) return slos_pkg::CMD_CLEAR;
		return slos_pkg::cmd_t'($urandom_range(0, 2));
	endfunction

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.cmd = slos_pkg::CMD_ADD;
		req_ch.key = '0;
		quiet = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// zero seed must fall back to one
		write_seed(32'd0);
		send_request(slos_pkg::CMD_ADD, 32'sh8000_0000);
		send_request(slos_pkg::CMD_ADD, slos_pkg::KEY_MAX);
		send_request(slos_pkg::CMD_CONTAINS, slos_pkg::KEY_MAX);
		send_request(slos_pkg::CMD_REMOVE, slos_pkg::KEY_MAX);
		send_request(slos_pkg::CMD_ADD, 32'sh8000_0000);
		send_request(slos_pkg::CMD_CONTAINS, 32'sh8000_0000);
		send_request(slos_pkg::CMD_ADD, 32'sh7FFF_FFFE);
		send_request(slos_pkg::CMD_ADD, 32'sd0);
		send_request(slos_pkg::CMD_ADD, -32'sd1);
		send_request(slos_pkg::CMD_CONTAINS, 32'sh7FFF_FFFE);
		send_request(slos_pkg::CMD_CONTAINS, 32'sd1);
		send_request(slos_pkg::CMD_REMOVE, 32'sh8000_0000);
		send_request(slos_pkg::CMD_REMOVE, 32'sh8000_0000);
		send_request(slos_pkg::CMD_CONTAINS, 32'sh8000_0000);
		send_request(slos_pkg::CMD_REMOVE, 32'sd0);
		send_request(slos_pkg::CMD_CLEAR, 32'sh5A5A_A5A5);
		send_request(slos_pkg::CMD_CONTAINS, -32'sd1);
		send_request(slos_pkg::CMD_ADD, -32'sd1);
		drain();

		write_seed(32'hFFFF_FFFF);
		repeat (60) send_request(pick_cmd(), pick_key());
		drain();

		// fill the whole pool, then push past it
		write_seed($urandom | 32'd1);
		send_request(slos_pkg::CMD_CLEAR, $urandom);
		for (int i = 0; i < slos_pkg::POOL_SIZE + 8; i++) begin
			int k;
			k = int'({$urandom_range(0, 32'h3FFF_FFFF), 1'b0}) ^ i;
			if (i < slos_pkg::POOL_SIZE) fill_keys.push_back(k);
			send_request(slos_pkg::CMD_ADD, k);
		end
		for (int i = 0; i < 20; i++) begin
			int k;
			k = fill_keys[$urandom_range(0, fill_keys.size() - 1)];
			send_request(slos_pkg::cmd_t'($urandom_range(0, 2)),
				($urandom_range(0, 3) == 0) ? $urandom : k);
		end
		send_request(slos_pkg::CMD_CLEAR, $urandom);
		drain();

		write_seed(32'h8000_0000);
		repeat (60) send_request(pick_cmd(), pick_key());
		quiet = 1'b1;
		repeat (40) send_request(pick_cmd(), pick_key());
		drain();

		if (sb.errors == 0 && sb.pending_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
`default_nettype wire

### skip_list_ordered_set.f
hdl/slos_pkg.sv
hdl/slos_req_if.sv
hdl/slos_rsp_if.sv
hdl/slos_ram.sv
hdl/skip_list_ordered_set.sv
tb/skip_list_ordered_set_tb.sv
